[rtl/core/dtcpi_pkg.sv]
package dtcpi_pkg;

  localparam int TableDepth = 16;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int EntW = 48;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  typedef enum logic [1:0] {
    FUNC_EVAL  = 2'd0,
    FUNC_LOADW = 2'd1,
    FUNC_LOADG = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_POLICY = 2'd0,
    CFG_WATER  = 2'd1,
    CFG_GAS    = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    POL_ERROR  = 2'd0,
    POL_CLAMP  = 2'd1,
    POL_LINEAR = 2'd2,
    POL_LIN3   = 2'd3
  } policy_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SREAD,
    ST_SLAST,
    ST_SCMP,
    ST_RNG,
    ST_RLO,
    ST_RHI,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_SUM,
    ST_RES
  } state_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [3:0]         entry_index;
    logic signed [15:0] entry_point;
    logic signed [31:0] entry_value;
    logic signed [15:0] water_sat;
    logic signed [15:0] gas_sat;
    logic signed [31:0] water_dp_measured;
    logic signed [31:0] gas_dp_measured;
    logic signed [31:0] water_enthalpy_term;
    logic signed [31:0] gas_enthalpy_term;
    logic signed [31:0] water_force_term;
    logic signed [31:0] gas_force_term;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] water_surface_energy;
    logic signed [31:0] gas_surface_energy;
    logic signed [31:0] water_reconstructed;
    logic signed [31:0] gas_reconstructed;
    logic signed [31:0] water_residual;
    logic signed [31:0] gas_residual;
    logic               water_range_error;
    logic               gas_range_error;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] quo;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[rtl/core/dtcpi_ram.sv]
module dtcpi_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/dtcpi_div.sv]
module dtcpi_div (
  input  logic                clk,
  input  logic                rst_n,
  input  dtcpi_pkg::div_req_t req,
  output dtcpi_pkg::div_stat_t stat
);

  logic [63:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r[31:0], quo_r[63]};
    if (req.start) begin
      quo_nxt  = req.num;
      den_nxt  = req.den;
      rem_nxt  = '0;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quo  = quo_r;

`ifndef NO_ASSERTIONS
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !req.start) |=> (cnt_r == $past(cnt_r) - 7'd1))
    else $error("divider count slipped");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider failed to start");
`endif

endmodule

[rtl/core/dual_table_capillary_pressure_interp_unit.sv]
// Channel | Dir | Handshake            | Payload
// in      | in  | in_valid/in_ready    | in_item_t
// out     | out | out_valid/out_ready  | out_item_t
// cfg     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
// Load item: written to its table RAM at the accepting edge.
// Evaluate item: no new item is accepted until it ends; per table one read of the
// last entry, n-1 scan reads, the setup states RNG, RLO, RHI, CALC and MUL, and a
// run on the shared 64-step divider; a clamped end or zero-width segment skips it.
// A waiting result stalls only the next evaluate item at its final step.
// Reset: synchronous active low, policy 0 and two entries per table.
module dual_table_capillary_pressure_interp_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dtcpi_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output dtcpi_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  dtcpi_pkg::state_t state_r, state_nxt;
  dtcpi_pkg::in_item_t item_r, item_nxt;
  dtcpi_pkg::out_item_t res_r, res_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] pol_r;
  logic [4:0] wcnt_r, gcnt_r;
  logic       side_r, side_nxt;
  dtcpi_pkg::idx_t i_r, i_nxt, low_r, low_nxt;
  logic signed [15:0] p0_r, p0_nxt, pl_r, pl_nxt, plo_r, plo_nxt;
  logic signed [31:0] v0_r, v0_nxt, vl_r, vl_nxt, vlo_r, vlo_nxt;
  logic signed [16:0] dx_r, dx_nxt, den_r, den_nxt;
  logic signed [32:0] dv_r, dv_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic       neg_r, neg_nxt, clamp_r, clamp_nxt, err_r, err_nxt;
  logic signed [31:0] ce_r, ce_nxt, we_r, we_nxt, ge_r, ge_nxt;
  logic       werr_r, werr_nxt, gerr_r, gerr_nxt;
  logic signed [31:0] wrc_r, wrc_nxt, grc_r, grc_nxt;

  logic            ram_we_w, ram_we_g;
  dtcpi_pkg::idx_t ram_wa, ram_ra;
  logic [dtcpi_pkg::EntW-1:0] ram_wd, rd_w, rd_g, rd;
  logic signed [15:0] rd_p, x;
  logic signed [31:0] rd_v;
  dtcpi_pkg::cnt_t n;
  dtcpi_pkg::idx_t last;
  dtcpi_pkg::div_req_t  dreq;
  dtcpi_pkg::div_stat_t dstat;
  logic [63:0] q_mag;
  logic signed [64:0] q_s;
  logic signed [65:0] e_sum;
  logic signed [31:0] e_val, e_fin;
  logic       out_free;

  dtcpi_ram #(.Width(dtcpi_pkg::EntW), .Depth(dtcpi_pkg::TableDepth)) u_wram (
    .clk, .we(ram_we_w), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(rd_w)
  );
  dtcpi_ram #(.Width(dtcpi_pkg::EntW), .Depth(dtcpi_pkg::TableDepth)) u_gram (
    .clk, .we(ram_we_g), .waddr(ram_wa), .wdata(ram_wd), .raddr(ram_ra), .rdata(rd_g)
  );
  dtcpi_div u_div (.clk, .rst_n, .req(dreq), .stat(dstat));

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == dtcpi_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign out_free  = !out_valid_r || out_ready;

  assign ram_wa   = in_data.entry_index[dtcpi_pkg::IdxW-1:0];
  assign ram_wd   = {in_data.entry_point, in_data.entry_value};
  assign ram_we_w = in_valid && in_ready && (in_data.func == dtcpi_pkg::FUNC_LOADW);
  assign ram_we_g = in_valid && in_ready && (in_data.func == dtcpi_pkg::FUNC_LOADG);

  assign rd   = side_r ? rd_g : rd_w;
  assign rd_p = rd[47:32];
  assign rd_v = rd[31:0];
  assign x    = side_r ? item_r.gas_sat : item_r.water_sat;

  always_comb begin
    logic [4:0] c;
    c = side_r ? gcnt_r : wcnt_r;
    if (c < 5'd2) begin
      n = dtcpi_pkg::cnt_t'(2);
    end else if (c > 5'(dtcpi_pkg::TableDepth)) begin
      n = dtcpi_pkg::cnt_t'(dtcpi_pkg::TableDepth);
    end else begin
      n = dtcpi_pkg::cnt_t'(c);
    end
    last = dtcpi_pkg::idx_t'(n - dtcpi_pkg::cnt_t'(1));
  end

  assign q_mag = dstat.quo;
  assign q_s   = neg_r ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
  assign e_sum = 66'(vlo_r) + 66'(q_s);
  assign e_val = dtcpi_pkg::sat32(e_sum);
  assign e_fin = clamp_r ? ce_r : ((den_r == '0) ? vlo_r : e_val);

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    side_nxt = side_r;
    i_nxt = i_r;
    low_nxt = low_r;
    p0_nxt = p0_r;
    pl_nxt = pl_r;
    v0_nxt = v0_r;
    vl_nxt = vl_r;
    plo_nxt = plo_r;
    vlo_nxt = vlo_r;
    dx_nxt = dx_r;
    den_nxt = den_r;
    dv_nxt = dv_r;
    prod_nxt = prod_r;
    neg_nxt = neg_r;
    clamp_nxt = clamp_r;
    err_nxt = err_r;
    ce_nxt = ce_r;
    we_nxt = we_r;
    ge_nxt = ge_r;
    werr_nxt = werr_r;
    gerr_nxt = gerr_r;
    wrc_nxt = wrc_r;
    grc_nxt = grc_r;
    ram_ra = i_r;
    dreq.start = 1'b0;
    dreq.num = prod_r[63] ? 64'(-prod_r) : 64'(prod_r);
    dreq.den = 32'(den_r[16] ? -den_r : den_r);
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      dtcpi_pkg::ST_IDLE: begin
        if (in_valid && in_data.func == dtcpi_pkg::FUNC_EVAL) begin
          item_nxt = in_data;
          side_nxt = 1'b0;
          state_nxt = dtcpi_pkg::ST_SREAD;
        end
      end
      dtcpi_pkg::ST_SREAD: begin
        ram_ra = last;
        i_nxt = '0;
        low_nxt = '0;
        state_nxt = dtcpi_pkg::ST_SLAST;
      end
      dtcpi_pkg::ST_SLAST: begin
        pl_nxt = rd_p;
        vl_nxt = rd_v;
        ram_ra = '0;
        state_nxt = dtcpi_pkg::ST_SCMP;
      end
      dtcpi_pkg::ST_SCMP: begin
        if (i_r == '0) begin
          p0_nxt = rd_p;
          v0_nxt = rd_v;
        end
        if (rd_p <= x) begin
          low_nxt = i_r;
        end
        if (i_r == dtcpi_pkg::idx_t'(last - dtcpi_pkg::idx_t'(1))) begin
          state_nxt = dtcpi_pkg::ST_RNG;
        end else begin
          ram_ra = dtcpi_pkg::idx_t'(i_r + dtcpi_pkg::idx_t'(1));
          i_nxt = dtcpi_pkg::idx_t'(i_r + dtcpi_pkg::idx_t'(1));
        end
      end
      dtcpi_pkg::ST_RNG: begin
        err_nxt = 1'b0;
        clamp_nxt = 1'b0;
        ce_nxt = (x < p0_r) ? v0_r : vl_r;
        if (x < p0_r || x > pl_r) begin
          if (pol_r == dtcpi_pkg::POL_ERROR) begin
            err_nxt = 1'b1;
          end else if (pol_r == dtcpi_pkg::POL_CLAMP) begin
            clamp_nxt = 1'b1;
          end
        end
        if (x >= pl_r) begin
          low_nxt = dtcpi_pkg::idx_t'(last - dtcpi_pkg::idx_t'(1));
        end
        state_nxt = dtcpi_pkg::ST_RLO;
      end
      dtcpi_pkg::ST_RLO: begin
        ram_ra = low_r;
        state_nxt = dtcpi_pkg::ST_RHI;
      end
      dtcpi_pkg::ST_RHI: begin
        ram_ra = dtcpi_pkg::idx_t'(low_r + dtcpi_pkg::idx_t'(1));
        plo_nxt = rd_p;
        vlo_nxt = rd_v;
        state_nxt = dtcpi_pkg::ST_CALC;
      end
      dtcpi_pkg::ST_CALC: begin
        den_nxt = 17'(rd_p) - 17'(plo_r);
        dv_nxt = 33'(rd_v) - 33'(vlo_r);
        dx_nxt = 17'(x) - 17'(plo_r);
        state_nxt = dtcpi_pkg::ST_MUL;
      end
      dtcpi_pkg::ST_MUL: begin
        prod_nxt = 64'(dv_r * dx_r);
        state_nxt = dtcpi_pkg::ST_DIV;
      end
      dtcpi_pkg::ST_DIV: begin
        if (clamp_r || den_r == '0 || dstat.done) begin
          if (!side_r) begin
            we_nxt = dtcpi_pkg::sat32(-66'(e_fin));
            werr_nxt = err_r;
            side_nxt = 1'b1;
            state_nxt = dtcpi_pkg::ST_SREAD;
          end else begin
            ge_nxt = e_fin;
            gerr_nxt = err_r;
            state_nxt = dtcpi_pkg::ST_SUM;
          end
        end else if (!dstat.busy) begin
          dreq.start = 1'b1;
          neg_nxt = prod_r[63] ^ den_r[16];
        end
      end
      dtcpi_pkg::ST_SUM: begin
        wrc_nxt = dtcpi_pkg::sat32(66'(we_r) + 66'(item_r.water_enthalpy_term)
          + 66'(item_r.water_force_term));
        grc_nxt = dtcpi_pkg::sat32(66'(ge_r) + 66'(item_r.gas_enthalpy_term)
          + 66'(item_r.gas_force_term));
        state_nxt = dtcpi_pkg::ST_RES;
      end
      dtcpi_pkg::ST_RES: begin
        if (out_free) begin
          res_nxt.water_surface_energy = we_r;
          res_nxt.gas_surface_energy = ge_r;
          res_nxt.water_reconstructed = wrc_r;
          res_nxt.gas_reconstructed = grc_r;
          res_nxt.water_residual = dtcpi_pkg::sat32(66'(item_r.water_dp_measured)
            - 66'(wrc_r));
          res_nxt.gas_residual = dtcpi_pkg::sat32(66'(item_r.gas_dp_measured)
            - 66'(grc_r));
          res_nxt.water_range_error = werr_r;
          res_nxt.gas_range_error = gerr_r;
          out_valid_nxt = 1'b1;
          state_nxt = dtcpi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dtcpi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtcpi_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      pol_r <= dtcpi_pkg::POL_ERROR;
      wcnt_r <= 5'd2;
      gcnt_r <= 5'd2;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          dtcpi_pkg::CFG_POLICY: pol_r <= cfg_data[1:0];
          dtcpi_pkg::CFG_WATER:  wcnt_r <= cfg_data[4:0];
          dtcpi_pkg::CFG_GAS:    gcnt_r <= cfg_data[4:0];
          default: begin
          end
        endcase
      end
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    side_r <= side_nxt;
    i_r <= i_nxt;
    low_r <= low_nxt;
    p0_r <= p0_nxt;
    pl_r <= pl_nxt;
    v0_r <= v0_nxt;
    vl_r <= vl_nxt;
    plo_r <= plo_nxt;
    vlo_r <= vlo_nxt;
    dx_r <= dx_nxt;
    den_r <= den_nxt;
    dv_r <= dv_nxt;
    prod_r <= prod_nxt;
    neg_r <= neg_nxt;
    clamp_r <= clamp_nxt;
    err_r <= err_nxt;
    ce_r <= ce_nxt;
    we_r <= we_nxt;
    ge_r <= ge_nxt;
    werr_r <= werr_nxt;
    gerr_r <= gerr_nxt;
    wrc_r <= wrc_nxt;
    grc_r <= grc_nxt;
  end

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(res_r)))
    else $error("result dropped or changed while waiting");
  a_ram_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we_w || ram_we_g) |-> state_r == dtcpi_pkg::ST_IDLE) else $error("load during eval");
  a_one_we: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we_w && ram_we_g)) else $error("both tables written");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    dreq.start |-> !dstat.busy) else $error("divider started while busy");
`endif

endmodule
